FILE: rtl/core/pulse_period_duty_capture_fifo_top_defines.svh
// Assertion helpers shared by the capture block.
`ifndef PULSE_PERIOD_DUTY_CAPTURE_FIFO_TOP_DEFINES_SVH
`define PULSE_PERIOD_DUTY_CAPTURE_FIFO_TOP_DEFINES_SVH

// Check a property on every clock edge, including edges while reset is held.
`define PPDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Check a property on clock edges outside reset.
`define PPDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

FILE: rtl/core/ppdc_pkg.sv
package ppdc_pkg;

  localparam int DVD_W  = 32;
  localparam int DVS_W  = 17;
  localparam int DUR_W  = 16;
  localparam int DUTY_W = 14;
  localparam int PROD_W = 30;

  localparam logic [DUTY_W-1:0] DUTY_SCALE = 14'd10000;

  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_POP     = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_CLR_OVF = 2'd3
  } ppdc_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_F_START,
    ST_F_WAIT,
    ST_D_START,
    ST_D_WAIT,
    ST_WRITE,
    ST_POP_READ,
    ST_POP_OUT
  } ppdc_state_t;

  typedef struct packed {
    logic [DUR_W-1:0]  high_time;
    logic [DUR_W-1:0]  low_time;
    logic [DVD_W-1:0]  frequency;
    logic [DUTY_W-1:0] duty;
    logic              valid;
  } ppdc_rec_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ppdc_div_stat_t;

endpackage

FILE: rtl/core/pulse_period_duty_capture_fifo_top.sv
// Channel   Handshake                   Payload
// input     start / busy                in_opcode, in_capture_count, in_pin_level_high
// result    out_valid (one-cycle pulse) out_status .. out_stored_count
// config    cfg_valid / cfg_ready       cfg_data (clock_rate)
//
// A capture edge that completes a valid record keeps busy high through two serial
// 32-step divisions (frequency, then duty) in one shared restoring divider, each
// after its own launch state, and through the ring write state; the result is
// registered from the write. A record with zero period or zero clock skips the
// divisions and goes straight to the write state.
// A pop of a held record is busy through a registered ring read and an output
// state; every other transaction posts its result the cycle after acceptance and
// never raises busy.
// Reset is synchronous, active low; it clears pointers, count, flags and the
// pending high time. Ring contents are undefined until written.
// The receiver cannot stall: each result shows for exactly one cycle.
module pulse_period_duty_capture_fifo_top #(
  parameter int RING_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_opcode,
  input  logic [ppdc_pkg::DUR_W-1:0]        in_capture_count,
  input  logic                              in_pin_level_high,
  // result channel
  output logic                              out_valid,
  output logic                              out_status,
  output logic [ppdc_pkg::DUR_W-1:0]        out_high_time,
  output logic [ppdc_pkg::DUR_W-1:0]        out_low_time,
  output logic [ppdc_pkg::DVD_W-1:0]        out_frequency_out,
  output logic [ppdc_pkg::DUTY_W-1:0]       out_duty_out,
  output logic                              out_record_valid,
  output logic                              out_data_ready,
  output logic                              out_overflow_flag,
  output logic [$clog2(RING_DEPTH+1)-1:0]   out_stored_count,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppdc_pkg::DVD_W-1:0]        cfg_data
);
  import ppdc_pkg::*;
  `include "pulse_period_duty_capture_fifo_top_defines.svh"

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  // Advance a ring pointer, wrapping at the ring depth.
  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    if (p == PTR_W'(RING_DEPTH - 1)) n = '0;
    else n = p + 1'b1;
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Control and ring state
  // ---------------------------------------------------------------------------
  ppdc_state_t        state_r, state_nxt;
  logic [DVD_W-1:0]   clock_rate_r;
  logic [DUR_W-1:0]   pending_r, pending_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;

  // Record being built
  logic [DUR_W-1:0]   lo_r;
  logic [DVS_W-1:0]   period_r;
  logic [PROD_W-1:0]  prod_r;
  logic [DVD_W-1:0]   freq_r;
  logic [DUTY_W-1:0]  duty_r;
  logic               rvalid_r;

  // Ring storage
  ppdc_rec_t          rec_mem [RING_DEPTH];
  ppdc_rec_t          rd_rec_r;
  ppdc_rec_t          wr_rec;

  // Result register
  logic               out_valid_r;
  logic               status_r;
  ppdc_rec_t          res_rec_r;
  logic               ovf_out_r;
  logic [CNT_W-1:0]   count_out_r;

  // Divider hookup
  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [DVD_W-1:0]   div_quotient;
  ppdc_div_stat_t     div_stat;

  // Decoded handshake
  ppdc_op_t           op;
  logic               accept;
  logic               completes;
  logic [DVS_W-1:0]   period_in;
  logic               pop_hit;
  logic               emit;
  logic               emit_pop;
  logic               emit_empty;
  logic               mem_we;
  logic               mem_re;

  assign op        = ppdc_op_t'(in_opcode);
  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign completes = (op == OP_CAPTURE) && in_pin_level_high;
  assign pop_hit   = (op == OP_POP) && (count_r != '0);
  assign period_in = {1'b0, pending_r} + {1'b0, in_capture_count};

  // Hold off configuration while a transaction is offered or running, so the
  // clock rate never changes under a record in progress.
  assign cfg_ready = !start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_rate_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      clock_rate_r <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (completes) begin
            // skip both divisions when the record is invalid
            if (period_in != '0 && clock_rate_r != '0) state_nxt = ST_F_START;
            else state_nxt = ST_WRITE;
          end else if (pop_hit) begin
            state_nxt = ST_POP_READ;
          end
        end
      end
      ST_F_START:  state_nxt = ST_F_WAIT;
      ST_F_WAIT:   if (div_stat.done) state_nxt = ST_D_START;
      ST_D_START:  state_nxt = ST_D_WAIT;
      ST_D_WAIT:   if (div_stat.done) state_nxt = ST_WRITE;
      ST_WRITE:    state_nxt = ST_IDLE;
      ST_POP_READ: state_nxt = ST_POP_OUT;
      ST_POP_OUT:  state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    div_start    = 1'b0;
    div_dividend = clock_rate_r;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    emit_pop     = 1'b0;
    emit         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // simple operations post their result right away
        emit = accept && !completes && !pop_hit;
      end
      ST_F_START: begin
        div_start    = 1'b1;
        div_dividend = clock_rate_r;
      end
      ST_F_WAIT: begin
      end
      ST_D_START: begin
        div_start    = 1'b1;
        div_dividend = {{(DVD_W - PROD_W){1'b0}}, prod_r};
      end
      ST_D_WAIT: begin
      end
      ST_WRITE: begin
        mem_we = 1'b1;
        emit   = 1'b1;
      end
      ST_POP_READ: begin
        mem_re = 1'b1;
      end
      ST_POP_OUT: begin
        emit_pop = 1'b1;
        emit     = 1'b1;
      end
    endcase
  end

  assign emit_empty = (state_r == ST_IDLE) && (op == OP_POP);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // ---------------------------------------------------------------------------
  // Shared divider: frequency first, then duty
  // ---------------------------------------------------------------------------
  ppdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (period_r),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  // Latch the operands at acceptance and form the duty numerator there too.
  always_ff @(posedge clk) begin
    if (accept && completes) begin
      lo_r     <= in_capture_count;
      period_r <= period_in;
      prod_r   <= {{(PROD_W - DUR_W){1'b0}}, pending_r}
                * {{(PROD_W - DUTY_W){1'b0}}, DUTY_SCALE};
      freq_r   <= '0;
      duty_r   <= '0;
      rvalid_r <= (period_in != '0) && (clock_rate_r != '0);
    end else if (div_stat.done && state_r == ST_F_WAIT) begin
      freq_r <= div_quotient;
    end else if (div_stat.done && state_r == ST_D_WAIT) begin
      duty_r <= div_quotient[DUTY_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Ring bookkeeping
  // ---------------------------------------------------------------------------
  always_comb begin
    pending_nxt = pending_r;
    wr_ptr_nxt  = wr_ptr_r;
    rd_ptr_nxt  = rd_ptr_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    if (accept) begin
      case (op)
        OP_CAPTURE: begin
          if (!in_pin_level_high) pending_nxt = in_capture_count;
        end
        OP_CLEAR: begin
          pending_nxt = '0;
          wr_ptr_nxt  = '0;
          rd_ptr_nxt  = '0;
          count_nxt   = '0;
          ovf_nxt     = 1'b0;
        end
        OP_CLR_OVF: ovf_nxt = 1'b0;
        default: begin
        end
      endcase
    end
    if (mem_we) begin
      wr_ptr_nxt = next_ptr(wr_ptr_r);
      if (count_r == CNT_W'(RING_DEPTH)) begin
        // full: drop the oldest record
        ovf_nxt    = 1'b1;
        rd_ptr_nxt = next_ptr(rd_ptr_r);
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
    if (emit_pop) begin
      rd_ptr_nxt = next_ptr(rd_ptr_r);
      count_nxt  = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      count_r   <= '0;
      ovf_r     <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      count_r   <= count_nxt;
      ovf_r     <= ovf_nxt;
    end
  end

  assign wr_rec.high_time = pending_r;
  assign wr_rec.low_time  = lo_r;
  assign wr_rec.frequency = freq_r;
  assign wr_rec.duty      = duty_r;
  assign wr_rec.valid     = rvalid_r;

  always_ff @(posedge clk) begin
    if (mem_we) rec_mem[wr_ptr_r] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_rec_r <= rec_mem[rd_ptr_r];
  end

  // ---------------------------------------------------------------------------
  // Result register: one-cycle strobe, status fields after the update
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= emit;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status_r    <= emit_empty;
      res_rec_r   <= emit_pop ? rd_rec_r : '0;
      ovf_out_r   <= ovf_nxt;
      count_out_r <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_high_time     = res_rec_r.high_time;
  assign out_low_time      = res_rec_r.low_time;
  assign out_frequency_out = res_rec_r.frequency;
  assign out_duty_out      = res_rec_r.duty;
  assign out_record_valid  = res_rec_r.valid;
  assign out_data_ready    = (count_out_r != '0);
  assign out_overflow_flag = ovf_out_r;
  assign out_stored_count  = count_out_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PPDC_ASSERT(a_count_bound, (count_r <= CNT_W'(RING_DEPTH)), "ring count over depth")
  `PPDC_ASSERT(a_empty_ptrs, (count_r == '0) |-> (rd_ptr_r == wr_ptr_r), "empty ring with split pointers")
  `PPDC_ASSERT(a_div_done, div_stat.done |-> (state_r == ST_F_WAIT || state_r == ST_D_WAIT), "divider done outside wait")
  `PPDC_ASSERT(a_div_launch, (state_r == ST_F_START || state_r == ST_D_START) |=> div_stat.busy, "divider did not launch")
  `PPDC_ASSERT(a_write_post, (state_r == ST_WRITE) |=> (out_valid && !busy), "record write without result")

endmodule

FILE: rtl/core/ppdc_div.sv
// Restoring divider, one quotient bit per cycle.
module ppdc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [ppdc_pkg::DVD_W-1:0]   dividend,
  input  logic [ppdc_pkg::DVS_W-1:0]   divisor,
  output logic [ppdc_pkg::DVD_W-1:0]   quotient,
  output ppdc_pkg::ppdc_div_stat_t     stat
);
  import ppdc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs_r};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract when it fits.
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: dv/pulse_period_duty_capture_fifo_top_tb.sv
`timescale 1ns / 1ps

module pulse_period_duty_capture_fifo_top_tb;
  import ppdc_pkg::*;

  localparam int RING_DEPTH  = 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  // Margin past the longest busy stretch, a completed record with its two divisions.
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_PRINTED   = 40;

  // One transaction on the input channel.
  typedef struct {
    ppdc_op_t    op;
    logic [15:0] dur;
    logic        pin;
  } edge_cmd_t;

  // One report on the result channel.
  typedef struct {
    logic        status;
    logic [15:0] high_time;
    logic [15:0] low_time;
    logic [31:0] frequency;
    logic [13:0] duty;
    logic        rec_valid;
    logic        data_ready;
    logic        overflow;
    logic [3:0]  stored;
  } meas_report_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_opcode = OP_CAPTURE;
  logic [15:0] in_capture_count = '0;
  logic        in_pin_level_high = 1'b0;
  logic        out_valid;
  logic        out_status;
  logic [15:0] out_high_time;
  logic [15:0] out_low_time;
  logic [31:0] out_frequency_out;
  logic [13:0] out_duty_out;
  logic        out_record_valid;
  logic        out_data_ready;
  logic        out_overflow_flag;
  logic [3:0]  out_stored_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  pulse_period_duty_capture_fifo_top #(
    .RING_DEPTH(RING_DEPTH)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_opcode         (in_opcode),
    .in_capture_count  (in_capture_count),
    .in_pin_level_high (in_pin_level_high),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_high_time     (out_high_time),
    .out_low_time      (out_low_time),
    .out_frequency_out (out_frequency_out),
    .out_duty_out      (out_duty_out),
    .out_record_valid  (out_record_valid),
    .out_data_ready    (out_data_ready),
    .out_overflow_flag (out_overflow_flag),
    .out_stored_count  (out_stored_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus waiting to go out, and reports the block still owes us.
  edge_cmd_t    edge_cmds_q[$];
  meas_report_t owed_reports_q[$];

  // Shadow copy of the block: ring, pointers, pending high time, flag, clock.
  logic [15:0] ring_high [RING_DEPTH];
  logic [15:0] ring_low  [RING_DEPTH];
  logic [31:0] ring_freq [RING_DEPTH];
  logic [13:0] ring_duty [RING_DEPTH];
  logic        ring_ok   [RING_DEPTH];
  logic [15:0] held_high;
  int          wr_slot;
  int          rd_slot;
  int          fill;
  logic        sticky_ovf;
  logic [31:0] timer_hz;

  int        idle_pct;
  logic      took_cmd;
  edge_cmd_t next_cmd;
  int        cycle_count;
  int        err_count;
  int        accepted_cnt;
  int        checked_cnt;
  int        records_cnt;
  int        invalid_cnt;
  int        pops_cnt;
  int        empty_pops_cnt;
  int        overwrite_cnt;
  int        clears_cnt;

  // Print one line per mismatch (up to a cap) and count every one.
  task automatic report_mismatch(input string what, input longint got, input longint want);
    if (err_count < MAX_PRINTED)
      $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h (report %0d)",
               $time, what, got, want, checked_cnt);
    err_count++;
  endtask

  // Advance the shadow state by one accepted transaction and queue its report.
  task automatic predict_capture_report(input logic [1:0] op, input logic [15:0] dur,
                                        input logic pin);
    meas_report_t rep;
    logic [16:0]  period;
    logic [31:0]  freq;
    logic [31:0]  duty;
    logic         ok;
    rep = '{default: '0};
    case (op)
      OP_CAPTURE: begin
        if (!pin) begin
          held_high = dur;
        end else begin
          period = {1'b0, held_high} + {1'b0, dur};
          freq = '0;
          duty = '0;
          ok = 1'b0;
          if (period != '0 && timer_hz != '0) begin
            freq = timer_hz / {15'd0, period};
            duty = ({16'd0, held_high} * 32'(DUTY_SCALE)) / {15'd0, period};
            ok = 1'b1;
          end
          ring_high[wr_slot] = held_high;
          ring_low[wr_slot]  = dur;
          ring_freq[wr_slot] = freq;
          ring_duty[wr_slot] = duty[13:0];
          ring_ok[wr_slot]   = ok;
          wr_slot = (wr_slot + 1) % RING_DEPTH;
          // A full ring drops its oldest record and latches the flag.
          if (fill < RING_DEPTH) begin
            fill++;
          end else begin
            sticky_ovf = 1'b1;
            rd_slot = (rd_slot + 1) % RING_DEPTH;
            overwrite_cnt++;
          end
          records_cnt++;
          if (!ok) invalid_cnt++;
        end
      end
      OP_POP: begin
        if (fill == 0) begin
          rep.status = 1'b1;
          empty_pops_cnt++;
        end else begin
          rep.high_time = ring_high[rd_slot];
          rep.low_time  = ring_low[rd_slot];
          rep.frequency = ring_freq[rd_slot];
          rep.duty      = ring_duty[rd_slot];
          rep.rec_valid = ring_ok[rd_slot];
          rd_slot = (rd_slot + 1) % RING_DEPTH;
          fill--;
          pops_cnt++;
        end
      end
      OP_CLEAR: begin
        wr_slot = 0;
        rd_slot = 0;
        fill = 0;
        sticky_ovf = 1'b0;
        held_high = '0;
        clears_cnt++;
      end
      default: begin
        sticky_ovf = 1'b0;
      end
    endcase
    rep.data_ready = (fill != 0);
    rep.overflow   = sticky_ovf;
    rep.stored     = 4'(fill);
    owed_reports_q.push_back(rep);
  endtask

  // Compare one report from the block with the oldest one owed.
  task automatic check_capture_report();
    meas_report_t want;
    if (owed_reports_q.size() == 0) begin
      report_mismatch("report with none owed, stored_count", out_stored_count, 0);
    end else begin
      want = owed_reports_q.pop_front();
      if (out_status !== want.status)
        report_mismatch("status", out_status, want.status);
      if (out_high_time !== want.high_time)
        report_mismatch("high_time", out_high_time, want.high_time);
      if (out_low_time !== want.low_time)
        report_mismatch("low_time", out_low_time, want.low_time);
      if (out_frequency_out !== want.frequency)
        report_mismatch("frequency_out", out_frequency_out, want.frequency);
      if (out_duty_out !== want.duty)
        report_mismatch("duty_out", out_duty_out, want.duty);
      if (out_record_valid !== want.rec_valid)
        report_mismatch("record_valid", out_record_valid, want.rec_valid);
      if (out_data_ready !== want.data_ready)
        report_mismatch("data_ready", out_data_ready, want.data_ready);
      if (out_overflow_flag !== want.overflow)
        report_mismatch("overflow_flag", out_overflow_flag, want.overflow);
      if (out_stored_count !== want.stored)
        report_mismatch("stored_count", out_stored_count, want.stored);
    end
    checked_cnt++;
  endtask

  // Monitor: take the report first, so a transaction accepted at this same
  // edge never lines up against a report that belongs to an older one.
  always @(posedge clk) begin
    took_cmd = 1'b0;
    if (rst_n) begin
      if (out_valid === 1'b1) check_capture_report();
      if (start && busy === 1'b0) begin
        took_cmd = 1'b1;
        accepted_cnt++;
        predict_capture_report(in_opcode, in_capture_count, in_pin_level_high);
      end
    end
  end

  // Driver: hold a transaction until accepted, then load the next one or idle.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || took_cmd) begin
      if (edge_cmds_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_cmd = edge_cmds_q.pop_front();
        start             <= 1'b1;
        in_opcode         <= next_cmd.op;
        in_capture_count  <= next_cmd.dur;
        in_pin_level_high <= next_cmd.pin;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reports owed", cycle_count,
               owed_reports_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic add_cmd(input ppdc_op_t op, input logic [15:0] dur, input logic pin);
    edge_cmd_t c;
    c.op  = op;
    c.dur = dur;
    c.pin = pin;
    edge_cmds_q.push_back(c);
  endtask

  // Durations: half from the full range, the rest zeros, maxima and short ones.
  function automatic logic [15:0] pick_ticks();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 50) return 16'($urandom_range(255, 1));
    return 16'($urandom_range(16'hFFFF));
  endfunction

  // Mostly high/low pairs with random content; some pops; rare clears; the
  // remainder lone edges that break the pairing.
  task automatic queue_random_traffic(input int n);
    int added;
    int r;
    added = 0;
    while (added < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        add_cmd(OP_CAPTURE, pick_ticks(), 1'b0);
        add_cmd(OP_CAPTURE, pick_ticks(), 1'b1);
        added += 2;
      end else if (r < 85) begin
        add_cmd(OP_POP, 16'($urandom), 1'($urandom));
        added++;
      end else if (r < 91) begin
        add_cmd(OP_CLR_OVF, 16'($urandom), 1'($urandom));
        added++;
      end else if (r < 94) begin
        add_cmd(OP_CLEAR, 16'($urandom), 1'($urandom));
        added++;
      end else begin
        add_cmd(OP_CAPTURE, pick_ticks(), 1'($urandom));
        added++;
      end
    end
  endtask

  // Hold off until the driver has emptied its queue and every report is in.
  task automatic drain_and_settle();
    while (edge_cmds_q.size() != 0 || start) @(posedge clk);
    while (owed_reports_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the clock rate register; the block is idle whenever this is called.
  task automatic write_timer_hz(input logic [31:0] hz);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= hz;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    timer_hz = hz;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    held_high = '0;
    wr_slot = 0;
    rd_slot = 0;
    fill = 0;
    sticky_ovf = 1'b0;
    timer_hz = '0;
    idle_pct = 0;
    took_cmd = 1'b0;
    cycle_count = 0;
    err_count = 0;
    accepted_cnt = 0;
    checked_cnt = 0;
    records_cnt = 0;
    invalid_cnt = 0;
    pops_cnt = 0;
    empty_pops_cnt = 0;
    overwrite_cnt = 0;
    clears_cnt = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(posedge clk);

    // Directed part at the top clock rate.
    write_timer_hz(32'hFFFF_FFFF);
    add_cmd(OP_POP, 16'hFFFF, 1'b1);          // pop on an empty ring
    add_cmd(OP_CAPTURE, 16'h0000, 1'b1);      // low time, no high yet: zero period
    add_cmd(OP_CAPTURE, 16'hFFFF, 1'b0);      // longest high time
    add_cmd(OP_CAPTURE, 16'hFFFF, 1'b1);      // longest period
    add_cmd(OP_CAPTURE, 16'h0000, 1'b1);      // reuse high time: full duty
    add_cmd(OP_CAPTURE, 16'h0000, 1'b0);
    add_cmd(OP_CAPTURE, 16'h0001, 1'b1);      // zero duty
    add_cmd(OP_CAPTURE, 16'h0001, 1'b0);
    add_cmd(OP_CAPTURE, 16'h0000, 1'b1);      // period of one tick
    add_cmd(OP_POP, 16'h0000, 1'b0);
    add_cmd(OP_CAPTURE, 16'h3039, 1'b1);
    add_cmd(OP_CAPTURE, 16'hAAAA, 1'b0);
    add_cmd(OP_CAPTURE, 16'h5555, 1'b1);
    add_cmd(OP_CAPTURE, 16'h8000, 1'b1);
    add_cmd(OP_CAPTURE, 16'h7FFF, 1'b1);      // fills the ring to its depth
    add_cmd(OP_CLR_OVF, 16'h1234, 1'b1);
    add_cmd(OP_POP, 16'h0000, 1'b0);
    add_cmd(OP_CLEAR, 16'hFFFF, 1'b0);
    add_cmd(OP_POP, 16'h0000, 1'b0);          // empty again after clear
    add_cmd(OP_CAPTURE, 16'h0064, 1'b1);      // pending high time cleared to zero
    add_cmd(OP_POP, 16'h0000, 1'b0);
    add_cmd(OP_CLR_OVF, 16'h0000, 1'b0);
    drain_and_settle();

    // No idling, a typical timer clock.
    write_timer_hz(32'd100_000_000);
    idle_pct = 0;
    queue_random_traffic(360);
    drain_and_settle();

    // Zero clock: every record invalid; sender idle most cycles. Pause in the
    // middle until every owed report is in.
    write_timer_hz(32'd0);
    idle_pct = 67;
    queue_random_traffic(180);
    drain_and_settle();
    queue_random_traffic(180);
    drain_and_settle();

    // One hertz; the receiver cannot stall, so this phase runs flat out.
    write_timer_hz(32'd1);
    idle_pct = 0;
    queue_random_traffic(360);
    drain_and_settle();

    // Random clock, light sender idling.
    write_timer_hz($urandom);
    idle_pct = 22;
    queue_random_traffic(360);
    drain_and_settle();

    if (owed_reports_q.size() != 0)
      report_mismatch("reports still owed at end", 0, owed_reports_q.size());

    $display("covered %0d transactions, %0d reports checked, %0d records (%0d invalid)",
             accepted_cnt, checked_cnt, records_cnt, invalid_cnt);
    $display("pops %0d, empty pops %0d, overwrites %0d, ring clears %0d, %0d cycles",
             pops_cnt, empty_pops_cnt, overwrite_cnt, clears_cnt, cycle_count);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ppdc_pkg.sv
rtl/core/ppdc_div.sv
rtl/core/pulse_period_duty_capture_fifo_top.sv
dv/pulse_period_duty_capture_fifo_top_tb.sv
